>>> rtl/ektt_pkg.sv
// shared types and constants for the expiring key timestamp table
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package ektt_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned TimeoutW = 32;

  localparam logic [TimeoutW-1:0] TimeoutReset = 32'd10;

  // opcode values of an input item
  localparam logic OpMark    = 1'b0;
  localparam logic OpExamine = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StDecide,
    StTsChk,
    StResp
  } ektt_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic issue;
    logic decide;
    logic ts_rd;
    logic ts_chk;
    logic load_out;
  } ektt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_last;
    logic found;
    logic op_examine;
    logic out_busy;
  } ektt_status_t;

endpackage

>>> rtl/ektt_ram.sv
// generic simple dual port ram with one write port and a registered read port
// no dependencies
`timescale 1ns / 1ps

module ektt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ektt_datapath.sv
// datapath: item registers, key and timestamp memories, valid bits, scan
// counter, match and free tracking, expiry compare and output register
// depends on ektt_pkg and ektt_ram
`timescale 1ns / 1ps

module ektt_datapath #(
  parameter int unsigned TABLE_ENTRIES = 128,
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ektt_pkg::ektt_cmd_t            cmd_i,
  output ektt_pkg::ektt_status_t         status_o,
  input  logic                           cfg_we_i,
  input  logic [ektt_pkg::TimeoutW-1:0]  cfg_wdata_i,
  input  logic                           opcode_i,
  input  logic [ektt_pkg::KeyW-1:0]      object_key_i,
  input  logic [ektt_pkg::TimeW-1:0]     time_seconds_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           stored_ok_o,
  output logic                           key_active_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  logic [ektt_pkg::TimeoutW-1:0] timeout_q;
  logic                          op_q;
  logic [ektt_pkg::KeyW-1:0]     key_q;
  logic [ektt_pkg::TimeW-1:0]    time_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IdxW-1:0]          rd_idx_q;
  logic                     cmp_vld_q;
  logic [IdxW-1:0]          cmp_idx_q;
  logic                     found_q;
  logic [IdxW-1:0]          found_idx_q;
  logic                     free_q;
  logic [IdxW-1:0]          free_idx_q;
  logic                     res_ok_q;
  logic                     res_act_q;
  logic                     out_valid_q;
  logic                     out_ok_q;
  logic                     out_act_q;

  logic [ektt_pkg::KeyW-1:0]  key_rdata;
  logic [ektt_pkg::TimeW-1:0] ts_rdata;
  logic [ektt_pkg::TimeW-1:0] limit;
  logic                       hit;
  logic                       empty_slot;
  logic                       slot_ok;
  logic [IdxW-1:0]            slot_idx;
  logic                       insert;
  logic                       ts_we;

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ektt_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= opcode_i;
      key_q  <= object_key_i;
      time_q <= time_seconds_i;
    end
  end

  // scan address counter and compare stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      cmp_vld_q <= cmd_i.issue;
      cmp_idx_q <= rd_idx_q;
      if (cmd_i.load_item) begin
        rd_idx_q <= '0;
      end else if (cmd_i.issue) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end
    end
  end

  // entry compare on the data read in the previous cycle
  assign hit        = cmp_vld_q && valid_q[cmp_idx_q] && (key_rdata == key_q);
  assign empty_slot = cmp_vld_q && !valid_q[cmp_idx_q];

  // first match and lowest free entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      found_idx_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
    end else if (cmd_i.load_item) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      if (hit && !found_q) begin
        found_q     <= 1'b1;
        found_idx_q <= cmp_idx_q;
      end
      if (empty_slot && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
    end
  end

  // mark update
  assign slot_ok  = found_q || free_q;
  assign slot_idx = found_q ? found_idx_q : free_idx_q;
  assign ts_we    = cmd_i.decide && (op_q == ektt_pkg::OpMark) && slot_ok;
  assign insert   = ts_we && !found_q;

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (insert) begin
      valid_q[free_idx_q] <= 1'b1;
    end
  end

  ektt_ram #(
    .Width (ektt_pkg::KeyW),
    .Depth (TABLE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (insert),
    .waddr_i (free_idx_q),
    .wdata_i (key_q),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_idx_q),
    .rdata_o (key_rdata)
  );

  ektt_ram #(
    .Width (ektt_pkg::TimeW),
    .Depth (TABLE_ENTRIES)
  ) u_ts_ram (
    .clk_i   (clk_i),
    .we_i    (ts_we),
    .waddr_i (slot_idx),
    .wdata_i (time_q),
    .re_i    (cmd_i.ts_rd),
    .raddr_i (found_idx_q),
    .rdata_o (ts_rdata)
  );

  // expiry limit wraps modulo 2^64
  assign limit = ts_rdata + {{(ektt_pkg::TimeW - ektt_pkg::TimeoutW){1'b0}}, timeout_q};

  // result bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_ok_q  <= (op_q == ektt_pkg::OpExamine) || slot_ok;
      res_act_q <= 1'b0;
    end else if (cmd_i.ts_chk) begin
      res_act_q <= limit > time_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ok_q  <= res_ok_q;
      out_act_q <= res_act_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign stored_ok_o  = out_ok_q;
  assign key_active_o = out_act_q;

  assign status_o.issue_last = (rd_idx_q == LastIdx);
  assign status_o.found      = found_q;
  assign status_o.op_examine = (op_q == ektt_pkg::OpExamine);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

>>> rtl/ektt_ctrl.sv
// controller state machine: accepts an item, sequences the scan, the update
// or expiry check and the hand-off to the output register
// depends on ektt_pkg
`timescale 1ns / 1ps

module ektt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ektt_pkg::ektt_status_t status_i,
  output ektt_pkg::ektt_cmd_t    cmd_o
);

  ektt_pkg::ektt_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ektt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ektt_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ektt_pkg::StScan;
        end
      end
      ektt_pkg::StScan: begin
        cmd_o.issue = 1'b1;
        if (status_i.issue_last) begin
          state_d = ektt_pkg::StDrain;
        end
      end
      ektt_pkg::StDrain: begin
        state_d = ektt_pkg::StDecide;
      end
      ektt_pkg::StDecide: begin
        cmd_o.decide = 1'b1;
        if (status_i.op_examine && status_i.found) begin
          cmd_o.ts_rd = 1'b1;
          state_d     = ektt_pkg::StTsChk;
        end else begin
          state_d = ektt_pkg::StResp;
        end
      end
      ektt_pkg::StTsChk: begin
        cmd_o.ts_chk = 1'b1;
        state_d      = ektt_pkg::StResp;
      end
      ektt_pkg::StResp: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ektt_pkg::StIdle;
        end
      end
      default: begin
        state_d = ektt_pkg::StIdle;
      end
    endcase
  end

endmodule

>>> rtl/expiring_key_timestamp_table.sv
// Expiring key timestamp table, top level: controller plus datapath.
// An item is accepted in idle, then the key memory is scanned through its single
// read port, one entry per cycle, followed by the drain, decide, timestamp check
// (examine that hits only) and response states; the next item is accepted only
// after the response state loads the result into the free output register.
// Reset clears all valid bits at once and sets the timeout to 10 seconds.
`timescale 1ns / 1ps

module expiring_key_timestamp_table #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] object_key_i,
  input  logic [63:0] time_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        stored_ok_o,
  output logic        key_active_o
);

  ektt_pkg::ektt_cmd_t    cmd;
  ektt_pkg::ektt_status_t status;

  ektt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ektt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .object_key_i   (object_key_i),
    .time_seconds_i (time_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .stored_ok_o    (stored_ok_o),
    .key_active_o   (key_active_o)
  );

  // a new result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && !out_ready_i))
    else $error("result loaded over a pending result");

  // one item at a time: no second accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while previous item in flight");

  // the scan runs without gaps until its last entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.issue && !status.issue_last) |=> cmd.issue)
    else $error("scan stopped before last entry");

  // no scan read, decide or timestamp check while the block is open for a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.issue || cmd.decide || cmd.ts_chk))
    else $error("datapath busy while accepting");

endmodule

>>> verif/tb_top.sv
// testbench for expiring_key_timestamp_table: random and directed mark/examine items
// checked against an in-bench table model; depends on rtl/ektt_pkg.sv and the top level
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TABLE_ENTRIES = 128;
  localparam int unsigned KeyW          = ektt_pkg::KeyW;
  localparam int unsigned TimeW         = ektt_pkg::TimeW;
  localparam int unsigned TimeoutW      = ektt_pkg::TimeoutW;

  typedef struct {
    logic                op;
    logic [KeyW-1:0]     key;
    logic [TimeW-1:0]    tstamp;
  } lookup_item_t;

  typedef struct {
    logic                op;
    logic [KeyW-1:0]     key;
    logic [TimeW-1:0]    tstamp;
    logic                stored_ok;
    logic                key_active;
  } lookup_reply_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [31:0]         cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                opcode_i       = ektt_pkg::OpMark;
  logic [KeyW-1:0]     object_key_i   = '0;
  logic [TimeW-1:0]    time_seconds_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                stored_ok_o;
  logic                key_active_o;

  // table copy used for prediction
  logic                tbl_valid [TABLE_ENTRIES];
  logic [KeyW-1:0]     tbl_key   [TABLE_ENTRIES];
  logic [TimeW-1:0]    tbl_stamp [TABLE_ENTRIES];
  logic [TimeoutW-1:0] timeout_now = ektt_pkg::TimeoutReset;

  // stimulus bookkeeping, in the order items will be accepted
  lookup_item_t        items_to_send [$];
  lookup_reply_t       replies_due [$];
  logic [TimeW-1:0]    stamp_seen [bit [KeyW-1:0]];
  logic [KeyW-1:0]     stored_keys [$];
  logic [KeyW-1:0]     dropped_keys [$];

  int                  send_idle_pct = 0;
  int                  rcv_idle_pct  = 0;
  int                  items_in      = 0;
  int                  hold_left     = 0;
  bit                  hold_done     = 1'b0;
  int                  err_count     = 0;

  expiring_key_timestamp_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .object_key_i  (object_key_i),
    .time_seconds_i(time_seconds_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .stored_ok_o   (stored_ok_o),
    .key_active_o  (key_active_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_stamp[i] = '0;
    end
  end

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // expected reply for one accepted item; updates the table copy
  function automatic lookup_reply_t table_predict(logic op, logic [KeyW-1:0] key,
                                                  logic [TimeW-1:0] tstamp);
    lookup_reply_t r;
    int hit;
    int free_slot;
    int i;
    r.op = op;
    r.key = key;
    r.tstamp = tstamp;
    r.stored_ok = 1'b0;
    r.key_active = 1'b0;
    hit = -1;
    free_slot = -1;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key && hit < 0) hit = i;
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
    end
    if (op == ektt_pkg::OpMark) begin
      // new key takes the lowest free entry; full table drops it
      if (hit < 0 && free_slot >= 0) begin
        tbl_valid[free_slot] = 1'b1;
        tbl_key[free_slot]   = key;
        hit = free_slot;
      end
      if (hit >= 0) begin
        tbl_stamp[hit] = tstamp;
        r.stored_ok = 1'b1;
      end
    end else begin
      r.stored_ok = 1'b1;
      // sum wraps at 64 bits before the compare
      if (hit >= 0) r.key_active = (tbl_stamp[hit] + TimeW'(timeout_now)) > tstamp;
    end
    return r;
  endfunction

  // queue one item and track which keys will end up in the table
  task automatic push_item(logic op, logic [KeyW-1:0] key, logic [TimeW-1:0] tstamp);
    lookup_item_t it;
    it.op = op;
    it.key = key;
    it.tstamp = tstamp;
    if (op == ektt_pkg::OpMark) begin
      if (!stamp_seen.exists(key)) begin
        if (stored_keys.size() < TABLE_ENTRIES) stored_keys.push_back(key);
        else dropped_keys.push_back(key);
      end
      stamp_seen[key] = tstamp;
    end
    items_to_send.push_back(it);
  endtask

  // random items, mostly on known keys with examine times near the expiry edge
  task automatic queue_random(int count, int fresh_pct);
    logic             op;
    logic [KeyW-1:0]  k;
    logic [TimeW-1:0] t;
    int               pick;
    for (int n = 0; n < count; n++) begin
      op = $urandom_range(1) ? ektt_pkg::OpExamine : ektt_pkg::OpMark;
      pick = $urandom_range(99);
      if (pick < fresh_pct || stored_keys.size() == 0) k = $urandom;
      else if (pick < fresh_pct + 5 && dropped_keys.size() != 0)
        k = dropped_keys[$urandom_range(dropped_keys.size() - 1)];
      else k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      if (op == ektt_pkg::OpMark) begin
        case ($urandom_range(2))
          0: t = {$urandom, $urandom};
          1: t = TimeW'($urandom_range(1000));
          default: t = '1 - TimeW'($urandom_range(1000));
        endcase
      end else if (stamp_seen.exists(k) && $urandom_range(99) < 70) begin
        t = stamp_seen[k] + TimeW'(timeout_now) + TimeW'($urandom_range(4)) - TimeW'(2);
      end else begin
        t = {$urandom, $urandom};
      end
      push_item(op, k, t);
    end
  endtask

  // sender pause: nothing queued, nothing offered, every reply back
  task automatic wait_all_done();
    do @(negedge clk_i);
    while (items_to_send.size() != 0 || in_valid_i || replies_due.size() != 0);
  endtask

  task automatic write_timeout(logic [TimeoutW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_now = value;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_item_t nxt;
    bit           take;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      opcode_i       <= ektt_pkg::OpMark;
      object_key_i   <= '0;
      time_seconds_i <= '0;
    end else begin
      take = in_valid_i && in_ready_o;
      if (take) begin
        replies_due.push_back(table_predict(opcode_i, object_key_i, time_seconds_i));
        items_in++;
      end
      if (!in_valid_i || take) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = items_to_send.pop_front();
          in_valid_i     <= 1'b1;
          opcode_i       <= nxt.op;
          object_key_i   <= nxt.key;
          time_seconds_i <= nxt.tstamp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while items keep coming
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_in == 350) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  // output monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_reply_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("result with no item outstanding");
        end else begin
          want = replies_due.pop_front();
          if (stored_ok_o !== want.stored_ok)
            flag_mismatch($sformatf("stored_ok op %0d key %h time %h got %b want %b",
                                    want.op, want.key, want.tstamp, stored_ok_o,
                                    want.stored_ok));
          if (key_active_o !== want.key_active)
            flag_mismatch($sformatf("key_active op %0d key %h time %h got %b want %b",
                                    want.op, want.key, want.tstamp, key_active_o,
                                    want.key_active));
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 25;
    rcv_idle_pct  = 64;

    // directed, reset timeout of 10
    push_item(ektt_pkg::OpExamine, 32'h0000_0000, 64'd0);
    push_item(ektt_pkg::OpMark,    32'h0000_0000, 64'd0);
    push_item(ektt_pkg::OpExamine, 32'h0000_0000, 64'd9);
    push_item(ektt_pkg::OpExamine, 32'h0000_0000, 64'd10);
    push_item(ektt_pkg::OpMark,    32'hFFFF_FFFF, '1);
    push_item(ektt_pkg::OpExamine, 32'hFFFF_FFFF, '1);
    push_item(ektt_pkg::OpExamine, 32'hFFFF_FFFF, 64'd8);
    push_item(ektt_pkg::OpMark,    32'h0000_0000, 64'd100);
    push_item(ektt_pkg::OpExamine, 32'h0000_0000, 64'd109);
    push_item(ektt_pkg::OpExamine, 32'h0000_0000, 64'd110);
    push_item(ektt_pkg::OpExamine, 32'h1234_5678, '1);
    push_item(ektt_pkg::OpMark,    32'hA5A5_A5A5, 64'h8000_0000_0000_0000);
    push_item(ektt_pkg::OpExamine, 32'hA5A5_A5A5, 64'h8000_0000_0000_0009);
    push_item(ektt_pkg::OpExamine, 32'h0000_0000, 64'd0);
    wait_all_done();

    // zero timeout: active only strictly before the stamp
    write_timeout('0);
    push_item(ektt_pkg::OpExamine, 32'h0000_0000, 64'd99);
    push_item(ektt_pkg::OpExamine, 32'h0000_0000, 64'd100);
    wait_all_done();

    // max timeout on a max stamp wraps around
    write_timeout('1);
    push_item(ektt_pkg::OpExamine, 32'hFFFF_FFFF, 64'h0000_0000_FFFF_FFFD);
    push_item(ektt_pkg::OpExamine, 32'hFFFF_FFFF, 64'h0000_0000_FFFF_FFFE);
    wait_all_done();

    // random, table partly filled
    write_timeout(TimeoutW'($urandom_range(1, 100)));
    queue_random(280, 15);
    wait_all_done();

    send_idle_pct = 64;
    rcv_idle_pct  = 25;
    write_timeout($urandom);
    queue_random(280, 15);
    wait_all_done();

    // fill the table and push past it, then mixed traffic on a full table
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    write_timeout(ektt_pkg::TimeoutReset);
    while (stored_keys.size() < TABLE_ENTRIES || dropped_keys.size() < 20)
      push_item(ektt_pkg::OpMark, $urandom, {$urandom, $urandom});
    wait_all_done();

    write_timeout(TimeoutW'($urandom_range(20)));
    queue_random(250, 15);
    wait_all_done();

    repeat (TABLE_ENTRIES + 16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> expiring_key_timestamp_table.f
rtl/ektt_pkg.sv
rtl/ektt_ram.sv
rtl/ektt_datapath.sv
rtl/ektt_ctrl.sv
rtl/expiring_key_timestamp_table.sv
verif/tb_top.sv
